>>> rtl/core/prp_pkg.sv
`default_nettype none

package prp_pkg;

    typedef enum logic [2:0] {
        PH_START  = 3'd0,
        PH_LENGTH = 3'd1,
        PH_KEY    = 3'd2,
        PH_VALUE  = 3'd3,
        PH_HALT   = 3'd4
    } phase_t;

    typedef enum logic [1:0] {
        ST_RUN     = 2'd0,
        ST_OK      = 2'd1,
        ST_INVALID = 2'd2,
        ST_CORRUPT = 2'd3
    } status_t;

    localparam logic [7:0] CHAR_EQUALS  = 8'h3D;
    localparam logic [7:0] CHAR_SPACE   = 8'h20;
    localparam logic [7:0] CHAR_ZERO    = 8'h30;
    localparam logic [7:0] CHAR_NINE    = 8'h39;
    localparam logic [7:0] CHAR_NEWLINE = 8'h0A;
    localparam logic [7:0] CHAR_NUL     = 8'h00;

    typedef struct packed {
        logic [7:0] out_byte;
        logic       key_strobe;
        logic       value_strobe;
        logic       record_done;
        status_t    parse_status;
    } result_t;

endpackage

`default_nettype wire

>>> rtl/core/prp_hdr_if.sv
`default_nettype none

interface prp_hdr_if;
    logic       valid;
    logic       ready;
    logic [7:0] data_byte;
    logic       block_end;

    modport source (output valid, output data_byte, output block_end, input ready);
    modport sink   (input valid, input data_byte, input block_end, output ready);
endinterface

`default_nettype wire

>>> rtl/core/prp_rec_if.sv
`default_nettype none

interface prp_rec_if;
    logic       valid;
    logic       ready;
    logic [7:0] out_byte;
    logic       key_strobe;
    logic       value_strobe;
    logic       record_done;
    logic [1:0] parse_status;

    modport source (output valid, output out_byte, output key_strobe, output value_strobe,
                    output record_done, output parse_status, input ready);
    modport sink   (input valid, input out_byte, input key_strobe, input value_strobe,
                    input record_done, input parse_status, output ready);
endinterface

`default_nettype wire

>>> rtl/core/pax_record_parser_unit.sv
`default_nettype none

// Channel | Role   | Payload
// --------+--------+----------------------------------------------------------
// hdr     | sink   | data_byte[7:0], block_end
// rec     | source | out_byte[7:0], key_strobe, value_strobe, record_done,
//         |        | parse_status[1:0]
//
// One byte per cycle sustained while rec takes results; each byte passes an
// input register and then a result register, and its result is presented on
// rec from the result register.
// The parser state advances as a byte moves from the input register to the
// result register, in one short step of compare and add logic.
// rst_n clears the parser to a record start with status running.
// A stall on rec holds the result register and then the input register; hdr
// stays ready while the input register is empty or about to move on.

module pax_record_parser_unit #(
    parameter int LEN_BITS = 20
) (
    input  wire logic clk,
    input  wire logic rst_n,
    prp_hdr_if.sink   hdr,
    prp_rec_if.source rec
);

    logic                hdr_valid_reg;
    logic [7:0]          hdr_byte_reg;
    logic                hdr_end_reg;
    prp_pkg::phase_t     phase_reg;
    prp_pkg::phase_t     phase_next;
    prp_pkg::status_t    status_reg;
    prp_pkg::status_t    status_next;
    logic [LEN_BITS-1:0] length_reg;
    logic [LEN_BITS-1:0] length_next;
    logic [LEN_BITS-1:0] count_reg;
    logic [LEN_BITS-1:0] count_next;
    logic                rec_valid_reg;
    prp_pkg::result_t    rec_reg;
    prp_pkg::result_t    rec_next;
    logic                advance;

    assign advance   = hdr_valid_reg && (!rec_valid_reg || rec.ready);
    assign hdr.ready = !hdr_valid_reg || advance;

    prp_step #(
        .LEN_BITS(LEN_BITS)
    ) u_step (
        .data_byte           (hdr_byte_reg),
        .block_end           (hdr_end_reg),
        .phase               (phase_reg),
        .status              (status_reg),
        .record_length       (length_reg),
        .bytes_in_record     (count_reg),
        .phase_next          (phase_next),
        .status_next         (status_next),
        .record_length_next  (length_next),
        .bytes_in_record_next(count_next),
        .result              (rec_next)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hdr_valid_reg <= 1'b0;
            rec_valid_reg <= 1'b0;
            phase_reg     <= prp_pkg::PH_START;
            status_reg    <= prp_pkg::ST_RUN;
            length_reg    <= '0;
            count_reg     <= '0;
        end
        else
        begin
            if (hdr.ready)
            begin
                hdr_valid_reg <= hdr.valid;
            end
            if (advance)
            begin
                rec_valid_reg <= 1'b1;
                phase_reg     <= phase_next;
                status_reg    <= status_next;
                length_reg    <= length_next;
                count_reg     <= count_next;
            end
            else if (rec.ready)
            begin
                rec_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (hdr.valid && hdr.ready)
        begin
            hdr_byte_reg <= hdr.data_byte;
            hdr_end_reg  <= hdr.block_end;
        end
        if (advance)
        begin
            rec_reg <= rec_next;
        end
    end

    assign rec.valid        = rec_valid_reg;
    assign rec.out_byte     = rec_reg.out_byte;
    assign rec.key_strobe   = rec_reg.key_strobe;
    assign rec.value_strobe = rec_reg.value_strobe;
    assign rec.record_done  = rec_reg.record_done;
    assign rec.parse_status = rec_reg.parse_status;

endmodule

`default_nettype wire

>>> rtl/core/prp_step.sv
`default_nettype none

module prp_step #(
    parameter int LEN_BITS = 20
) (
    input  wire logic [7:0]          data_byte,
    input  wire logic                block_end,
    input  wire prp_pkg::phase_t     phase,
    input  wire prp_pkg::status_t    status,
    input  wire logic [LEN_BITS-1:0] record_length,
    input  wire logic [LEN_BITS-1:0] bytes_in_record,
    output prp_pkg::phase_t          phase_next,
    output prp_pkg::status_t         status_next,
    output logic [LEN_BITS-1:0]      record_length_next,
    output logic [LEN_BITS-1:0]      bytes_in_record_next,
    output prp_pkg::result_t         result
);

    localparam logic [LEN_BITS-1:0] LEN_MAX = {LEN_BITS{1'b1}};

    logic                is_digit;
    logic [LEN_BITS+3:0] len_times_ten;
    logic                len_overflow;
    logic [LEN_BITS-1:0] count_inc;
    logic                last_byte;
    prp_pkg::phase_t     step_phase;
    prp_pkg::status_t    step_status;
    prp_pkg::status_t    shown_status;
    logic                ends_corrupt;

    assign is_digit = (data_byte >= prp_pkg::CHAR_ZERO) && (data_byte <= prp_pkg::CHAR_NINE);
    // Times ten as two shifted adds plus the digit, kept four bits wide above the length.
    assign len_times_ten = {1'b0, record_length, 3'b000} + {3'b000, record_length, 1'b0}
                         + {{LEN_BITS{1'b0}}, data_byte[3:0]};
    assign len_overflow  = |len_times_ten[LEN_BITS+3:LEN_BITS];
    assign count_inc     = (bytes_in_record != LEN_MAX) ? bytes_in_record + 1'b1
                                                        : bytes_in_record;
    assign last_byte     = (count_inc == record_length);

    // Next state of the record parser.
    always_comb
    begin
        step_phase           = phase;
        step_status          = status;
        record_length_next   = record_length;
        bytes_in_record_next = bytes_in_record;
        unique case (phase)
            prp_pkg::PH_START:
            begin
                if (data_byte == prp_pkg::CHAR_NUL)
                begin
                    step_phase  = prp_pkg::PH_HALT;
                    step_status = prp_pkg::ST_OK;
                end
                else if (is_digit)
                begin
                    record_length_next   = {{(LEN_BITS-4){1'b0}}, data_byte[3:0]};
                    bytes_in_record_next = {{(LEN_BITS-1){1'b0}}, 1'b1};
                    step_phase           = prp_pkg::PH_LENGTH;
                end
                else
                begin
                    step_phase  = prp_pkg::PH_HALT;
                    step_status = prp_pkg::ST_INVALID;
                end
            end
            prp_pkg::PH_LENGTH:
            begin
                if (is_digit)
                begin
                    if (len_overflow)
                    begin
                        step_phase  = prp_pkg::PH_HALT;
                        step_status = prp_pkg::ST_INVALID;
                    end
                    else
                    begin
                        record_length_next   = len_times_ten[LEN_BITS-1:0];
                        bytes_in_record_next = count_inc;
                    end
                end
                else if (data_byte == prp_pkg::CHAR_SPACE)
                begin
                    bytes_in_record_next = count_inc;
                    // A zero length also fails here, since the count is never zero.
                    if (record_length <= count_inc)
                    begin
                        step_phase  = prp_pkg::PH_HALT;
                        step_status = prp_pkg::ST_INVALID;
                    end
                    else
                    begin
                        step_phase = prp_pkg::PH_KEY;
                    end
                end
                else
                begin
                    step_phase  = prp_pkg::PH_HALT;
                    step_status = prp_pkg::ST_INVALID;
                end
            end
            prp_pkg::PH_KEY:
            begin
                bytes_in_record_next = count_inc;
                if (data_byte == prp_pkg::CHAR_EQUALS)
                begin
                    // A separator on the last byte closes a record with an empty value.
                    if (last_byte)
                    begin
                        step_phase           = prp_pkg::PH_START;
                        record_length_next   = '0;
                        bytes_in_record_next = '0;
                    end
                    else
                    begin
                        step_phase = prp_pkg::PH_VALUE;
                    end
                end
                else if (last_byte)
                begin
                    step_phase  = prp_pkg::PH_HALT;
                    step_status = prp_pkg::ST_INVALID;
                end
            end
            prp_pkg::PH_VALUE:
            begin
                bytes_in_record_next = count_inc;
                if (last_byte)
                begin
                    step_phase           = prp_pkg::PH_START;
                    record_length_next   = '0;
                    bytes_in_record_next = '0;
                end
            end
            default:
            begin
                step_phase = phase;
            end
        endcase

        ends_corrupt = 1'b0;
        shown_status = step_status;
        status_next  = step_status;
        phase_next   = step_phase;
        if (block_end)
        begin
            if (step_status == prp_pkg::ST_RUN)
            begin
                if (step_phase == prp_pkg::PH_START)
                begin
                    shown_status = prp_pkg::ST_OK;
                end
                else if (step_phase == prp_pkg::PH_LENGTH)
                begin
                    shown_status = prp_pkg::ST_INVALID;
                end
                else
                begin
                    shown_status = prp_pkg::ST_CORRUPT;
                    ends_corrupt = 1'b1;
                end
            end
            // The next byte opens a new block.
            status_next          = prp_pkg::ST_RUN;
            phase_next           = prp_pkg::PH_START;
            record_length_next   = '0;
            bytes_in_record_next = '0;
        end
    end

    // Result of this byte.
    always_comb
    begin
        result              = '0;
        result.parse_status = shown_status;
        if (!ends_corrupt)
        begin
            unique case (phase)
                prp_pkg::PH_KEY:
                begin
                    if (data_byte == prp_pkg::CHAR_EQUALS)
                    begin
                        result.record_done = last_byte;
                    end
                    else if (!last_byte)
                    begin
                        result.out_byte   = data_byte;
                        result.key_strobe = 1'b1;
                    end
                end
                prp_pkg::PH_VALUE:
                begin
                    if (!(last_byte && data_byte == prp_pkg::CHAR_NEWLINE))
                    begin
                        result.out_byte     = data_byte;
                        result.value_strobe = 1'b1;
                    end
                    result.record_done = last_byte;
                end
                default:
                begin
                    result.out_byte = '0;
                end
            endcase
        end
    end

endmodule

`default_nettype wire

>>> sim/pax_record_parser_unit_tb.sv
module pax_record_parser_unit_tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int              LEN_BITS    = 20;
    localparam longint unsigned LEN_MAX     = (longint'(1) << LEN_BITS) - 1;
    localparam int              CYCLE_LIMIT = 500000;

    logic clk;
    logic rst_n;

    prp_hdr_if hdr_ch ();
    prp_rec_if rec_ch ();

    pax_record_parser_unit #(
        .LEN_BITS(LEN_BITS)
    ) u_dut (
        .clk  (clk),
        .rst_n(rst_n),
        .hdr  (hdr_ch),
        .rec  (rec_ch)
    );

    // Parser state as the testbench expects it, advanced once per accepted byte.
    prp_pkg::phase_t  pred_phase  = prp_pkg::PH_START;
    longint unsigned  pred_length = 0;
    longint unsigned  pred_count  = 0;
    prp_pkg::status_t pred_status = prp_pkg::ST_RUN;

    prp_pkg::result_t parse_results_due[$];
    int               error_count = 0;
    int               bytes_sent  = 0;
    int               cycle_count = 0;
    bit               calm        = 1'b0;

    initial begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    always @(posedge clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("%0t: timeout with %0d results outstanding", $time,
                     parse_results_due.size());
            $display("pax_record_parser_unit_tb: FAIL");
            $finish;
        end
    end

    function automatic void stop_parse(input prp_pkg::status_t code);
        pred_status = code;
        pred_phase  = prp_pkg::PH_HALT;
    endfunction

    function automatic void count_record_byte();
        if (pred_count < LEN_MAX)
            pred_count++;
    endfunction

    function automatic prp_pkg::result_t parse_byte(input logic [7:0] b,
                                                    input logic last_in_block);
        prp_pkg::result_t r;
        logic             is_digit;
        logic             at_last;
        longint unsigned  next_len;
        r = '0;
        is_digit = (b >= prp_pkg::CHAR_ZERO) && (b <= prp_pkg::CHAR_NINE);
        case (pred_phase)
            prp_pkg::PH_START:
                if (b == prp_pkg::CHAR_NUL)
                    stop_parse(prp_pkg::ST_OK);
                else if (is_digit)
                begin
                    pred_length = b - prp_pkg::CHAR_ZERO;
                    pred_count  = 1;
                    pred_phase  = prp_pkg::PH_LENGTH;
                end
                else
                    stop_parse(prp_pkg::ST_INVALID);
            prp_pkg::PH_LENGTH:
                if (is_digit)
                begin
                    next_len = pred_length * 10 + (b - prp_pkg::CHAR_ZERO);
                    if (next_len > LEN_MAX)
                        stop_parse(prp_pkg::ST_INVALID);
                    else
                    begin
                        pred_length = next_len;
                        count_record_byte();
                    end
                end
                else if (b == prp_pkg::CHAR_SPACE)
                begin
                    count_record_byte();
                    if (pred_length == 0 || pred_length <= pred_count)
                        stop_parse(prp_pkg::ST_INVALID);
                    else
                        pred_phase = prp_pkg::PH_KEY;
                end
                else
                    stop_parse(prp_pkg::ST_INVALID);
            prp_pkg::PH_KEY, prp_pkg::PH_VALUE:
            begin
                count_record_byte();
                at_last = (pred_count == pred_length);
                if (pred_phase == prp_pkg::PH_KEY && b == prp_pkg::CHAR_EQUALS)
                    pred_phase = prp_pkg::PH_VALUE;
                else if (!(at_last && b == prp_pkg::CHAR_NEWLINE))
                begin
                    r.out_byte = b;
                    if (pred_phase == prp_pkg::PH_KEY)
                        r.key_strobe = 1'b1;
                    else
                        r.value_strobe = 1'b1;
                end
                // A key that runs to the end of the record has no separator.
                if (at_last)
                begin
                    if (pred_phase == prp_pkg::PH_KEY)
                    begin
                        r.out_byte   = '0;
                        r.key_strobe = 1'b0;
                        stop_parse(prp_pkg::ST_INVALID);
                    end
                    else
                    begin
                        r.record_done = 1'b1;
                        pred_phase    = prp_pkg::PH_START;
                        pred_length   = 0;
                        pred_count    = 0;
                    end
                end
            end
            default: ;
        endcase

        if (last_in_block && pred_status == prp_pkg::ST_RUN)
        begin
            if (pred_phase == prp_pkg::PH_START)
                pred_status = prp_pkg::ST_OK;
            else if (pred_phase == prp_pkg::PH_LENGTH)
                pred_status = prp_pkg::ST_INVALID;
            else
            begin
                pred_status    = prp_pkg::ST_CORRUPT;
                r.out_byte     = '0;
                r.key_strobe   = 1'b0;
                r.value_strobe = 1'b0;
            end
        end
        r.parse_status = pred_status;

        if (last_in_block)
        begin
            pred_phase  = prp_pkg::PH_START;
            pred_length = 0;
            pred_count  = 0;
            pred_status = prp_pkg::ST_RUN;
        end
        return r;
    endfunction

    task automatic report_field(input string field, input logic [7:0] want,
                                input logic [7:0] got);
        $display("%0t: %s mismatch, expected %0h actual %0h", $time, field, want, got);
        error_count++;
    endtask

    // Result side: random stalls, and every transaction is checked in order.
    initial begin
        int               stall;
        prp_pkg::result_t want;
        rec_ch.ready = 1'b0;
        wait (rst_n === 1'b1);
        @(posedge clk);
        forever
        begin
            stall = calm ? 0 : $urandom_range(0, 10);
            if (stall > 0)
            begin
                rec_ch.ready <= 1'b0;
                repeat (stall) @(posedge clk);
            end
            rec_ch.ready <= 1'b1;
            do @(posedge clk); while (rec_ch.valid !== 1'b1);
            if (parse_results_due.size() == 0)
            begin
                $display("%0t: unexpected result transaction, byte %0h status %0d", $time,
                         rec_ch.out_byte, rec_ch.parse_status);
                error_count++;
            end
            else
            begin
                want = parse_results_due.pop_front();
                if (rec_ch.out_byte !== want.out_byte)
                    report_field("out_byte", want.out_byte, rec_ch.out_byte);
                if (rec_ch.key_strobe !== want.key_strobe)
                    report_field("key_strobe", want.key_strobe, rec_ch.key_strobe);
                if (rec_ch.value_strobe !== want.value_strobe)
                    report_field("value_strobe", want.value_strobe, rec_ch.value_strobe);
                if (rec_ch.record_done !== want.record_done)
                    report_field("record_done", want.record_done, rec_ch.record_done);
                if (rec_ch.parse_status !== want.parse_status)
                    report_field("parse_status", want.parse_status, rec_ch.parse_status);
            end
        end
    end

    task automatic send_byte(input logic [7:0] b, input logic last_in_block);
        int gap;
        gap = calm ? 0 : $urandom_range(0, 10);
        if (gap > 0)
        begin
            hdr_ch.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        hdr_ch.valid     <= 1'b1;
        hdr_ch.data_byte <= b;
        hdr_ch.block_end <= last_in_block;
        do @(posedge clk); while (hdr_ch.ready !== 1'b1);
        parse_results_due.insert(parse_results_due.size(), parse_byte(b, last_in_block));
        bytes_sent++;
    endtask

    task automatic send_block(ref logic [7:0] blk[$]);
        for (int i = 0; i < blk.size(); i++)
            send_byte(blk[i], i == blk.size() - 1);
    endtask

    // Stop sending and let every outstanding result come back.
    task automatic wait_results_drained();
        hdr_ch.valid <= 1'b0;
        do @(posedge clk); while (parse_results_due.size() != 0);
    endtask

    task automatic add_byte(ref logic [7:0] blk[$], input logic [7:0] b);
        blk.insert(blk.size(), b);
    endtask

    task automatic push_text(ref logic [7:0] blk[$], input string s);
        foreach (s[i])
            add_byte(blk, s[i]);
    endtask

    task automatic send_text(input string s);
        logic [7:0] blk[$];
        push_text(blk, s);
        send_block(blk);
    endtask

    // Appends "<len> <key>=<value>\n" with a self-consistent length field; the
    // '=' and the newline are optional, and the skew makes it wrong on purpose.
    task automatic add_record(ref logic [7:0] blk[$], input int key_len, input int val_len,
                              input bit has_eq, input bit has_nl, input int lead_zeros,
                              input int len_skew);
        int         body;
        int         ndig;
        int         total;
        string      len_txt;
        logic [7:0] k;
        body = key_len + (has_eq ? 1 : 0) + val_len + (has_nl ? 1 : 0);
        ndig = 1;
        len_txt = $sformatf("%0d", lead_zeros + ndig + 1 + body);
        while (len_txt.len() > ndig)
        begin
            ndig++;
            len_txt = $sformatf("%0d", lead_zeros + ndig + 1 + body);
        end
        total = lead_zeros + ndig + 1 + body;
        repeat (lead_zeros) add_byte(blk, prp_pkg::CHAR_ZERO);
        push_text(blk, $sformatf("%0d", total + len_skew));
        add_byte(blk, prp_pkg::CHAR_SPACE);
        repeat (key_len)
        begin
            do k = 8'($urandom_range(0, 255)); while (k == prp_pkg::CHAR_EQUALS);
            add_byte(blk, k);
        end
        if (has_eq)
            add_byte(blk, prp_pkg::CHAR_EQUALS);
        repeat (val_len) add_byte(blk, 8'($urandom_range(0, 255)));
        if (has_nl)
            add_byte(blk, prp_pkg::CHAR_NEWLINE);
    endtask

    task automatic make_clean_block(ref logic [7:0] blk[$]);
        int nrec;
        int val_len;
        int zeros;
        blk.delete();
        nrec = $urandom_range(1, 4);
        repeat (nrec)
        begin
            val_len = ($urandom_range(0, 15) == 0) ? $urandom_range(60, 300)
                                                   : $urandom_range(0, 12);
            zeros   = ($urandom_range(0, 7) == 0) ? $urandom_range(1, 2) : 0;
            add_record(blk, $urandom_range(0, 6), val_len, 1'b1, $urandom_range(0, 3) != 0,
                       zeros, 0);
        end
        case ($urandom_range(0, 2))
            1: add_byte(blk, prp_pkg::CHAR_NUL);
            2:
            begin
                add_byte(blk, prp_pkg::CHAR_NUL);
                repeat ($urandom_range(1, 3)) add_byte(blk, 8'($urandom_range(0, 255)));
            end
            default: ;
        endcase
    endtask

    task automatic test_directed();
        logic [7:0] blk[$];
        send_text("6 a=b\n");
        // A zero byte at a record start finishes; what follows is ignored.
        blk = '{prp_pkg::CHAR_NUL, 8'hFF};
        send_block(blk);
        send_text("x");
        send_text("9");
        send_text("5x");
        send_text("0 ");
        send_text("2 ");
        send_text("3 \n");
        send_text("9999999");
        send_text("9 a");
        wait_results_drained();
    endtask

    task automatic test_clean_blocks(input int byte_target);
        logic [7:0] blk[$];
        int         blk_idx;
        blk_idx = 0;
        while (bytes_sent < byte_target)
        begin
            // Three blocks in every ten run back to back on both sides.
            calm = (blk_idx % 10) >= 7;
            make_clean_block(blk);
            send_block(blk);
            blk_idx++;
        end
        calm = 1'b0;
        wait_results_drained();
    endtask

    task automatic test_midblock_pause();
        logic [7:0] blk[$];
        int         half;
        repeat (3)
        begin
            make_clean_block(blk);
            half = blk.size() / 2;
            for (int i = 0; i < blk.size(); i++)
            begin
                if (i == half && half > 0)
                    wait_results_drained();
                send_byte(blk[i], i == blk.size() - 1);
            end
        end
        wait_results_drained();
    endtask

    task automatic test_damaged_blocks(input int byte_target);
        logic [7:0]      blk[$];
        logic [7:0]      tail;
        longint unsigned big_len;
        int              cut;
        int              skew;
        while (bytes_sent < byte_target)
        begin
            blk.delete();
            case ($urandom_range(0, 5))
                0:
                begin
                    if ($urandom_range(0, 1))
                        add_record(blk, $urandom_range(0, 6), $urandom_range(0, 12),
                                   1'b1, 1'b1, 0, 0);
                    do skew = $urandom_range(0, 8) - 4; while (skew == 0);
                    add_record(blk, $urandom_range(0, 6), $urandom_range(0, 12), 1'b1,
                               $urandom_range(0, 1), 0, skew);
                end
                1:
                    add_record(blk, $urandom_range(0, 8), 0, 1'b0, $urandom_range(0, 1), 0, 0);
                2:
                begin
                    make_clean_block(blk);
                    if (blk.size() > 1)
                    begin
                        cut = $urandom_range(1, blk.size() - 1);
                        repeat (cut) void'(blk.pop_back());
                    end
                end
                3:
                    repeat ($urandom_range(1, 8)) add_byte(blk, 8'($urandom_range(0, 255)));
                4:
                begin
                    // Length fields around the largest value the counter holds.
                    big_len = LEN_MAX - 3 + $urandom_range(0, 6);
                    push_text(blk, $sformatf("%0d", big_len));
                    add_byte(blk, prp_pkg::CHAR_SPACE);
                    repeat ($urandom_range(0, 3)) add_byte(blk, 8'($urandom_range(0, 255)));
                end
                default:
                begin
                    repeat ($urandom_range(1, 3))
                        add_byte(blk, 8'(prp_pkg::CHAR_ZERO + $urandom_range(0, 9)));
                    do tail = 8'($urandom_range(0, 255)); while (tail == prp_pkg::CHAR_SPACE);
                    add_byte(blk, tail);
                end
            endcase
            if ($urandom_range(0, 1))
                add_record(blk, $urandom_range(0, 6), $urandom_range(0, 12), 1'b1, 1'b1, 0, 0);
            send_block(blk);
        end
        wait_results_drained();
    endtask

    initial begin
        rst_n            = 1'b0;
        hdr_ch.valid     = 1'b0;
        hdr_ch.data_byte = '0;
        hdr_ch.block_end = 1'b0;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_directed();
        test_clean_blocks(1100);
        test_midblock_pause();
        test_damaged_blocks(1700);

        repeat (10) @(posedge clk);
        if (error_count == 0 && parse_results_due.size() == 0)
            $display("pax_record_parser_unit_tb: PASS");
        else
            $display("pax_record_parser_unit_tb: FAIL");
        $finish;
    end

endmodule

>>> sim.f
rtl/core/prp_pkg.sv
rtl/core/prp_hdr_if.sv
rtl/core/prp_rec_if.sv
rtl/core/prp_step.sv
rtl/core/pax_record_parser_unit.sv
sim/pax_record_parser_unit_tb.sv
